>>> design/gbns_pkg.sv
// Shared types and constants for the go-back-n sender core.
// No dependencies; imported by the controller, the datapath and the top level.
package gbns_pkg;

    // Default values for the top-level parameters
    localparam int DEF_WINDOW       = 4;
    localparam int DEF_SEQ_SPACE    = 8;
    localparam int DEF_PAYLOAD_BITS = 64;

    // Fixed port widths
    localparam int OP_W       = 2;
    localparam int DATA_PORT_W = 64;
    localparam int SEQ_PORT_W = 3;
    localparam int CNT_PORT_W = 3;
    localparam int TMR_W      = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

    // Timer commands
    localparam logic [TMR_W-1:0] TMR_NONE  = 2'd0;
    localparam logic [TMR_W-1:0] TMR_START = 2'd1;
    localparam logic [TMR_W-1:0] TMR_STOP  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic accept;       // input transfer: run one send/ack/timeout step
        logic replay_load;  // move fetched entry into the output register
        logic replay_next;  // advance replay pointer, fetch next entry
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic replay_needed; // current input is a timeout with packets in flight
        logic out_last;      // output register holds the final result of the step
    } t_dp_status;

endpackage

>>> design/gbns_ctrl.sv
// Sequencing controller for the go-back-n sender core.
// Depends on gbns_pkg; drives the handshakes and commands the datapath.
module gbns_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  gbns_pkg::t_dp_status i_status,
    output gbns_pkg::t_dp_cmd    o_cmd
);
    import gbns_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_in_stall        = 1'b1;
        o_out_valid       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_status.replay_needed ? S_FETCH : S_EMIT;
                end
            end
            S_FETCH: begin
                // registered memory read is ready now
                o_cmd.replay_load = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (i_status.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.replay_next = 1'b1;
                        n_state = S_FETCH;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/gbns_datapath.sv
// Window state, packet store and result register for the go-back-n sender core.
// Depends on gbns_pkg; stepped by commands from gbns_ctrl.
module gbns_datapath #(
    parameter int WINDOW       = gbns_pkg::DEF_WINDOW,
    parameter int SEQ_SPACE    = gbns_pkg::DEF_SEQ_SPACE,
    parameter int PAYLOAD_BITS = gbns_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gbns_pkg::t_dp_cmd                   i_cmd,
    output gbns_pkg::t_dp_status                o_status,
    input  logic [gbns_pkg::OP_W-1:0]           i_operation,
    input  logic [gbns_pkg::DATA_PORT_W-1:0]    i_payload_word,
    input  logic [gbns_pkg::SEQ_PORT_W-1:0]     i_ack_seq,
    input  logic                                i_ack_good,
    output logic                                o_accepted,
    output logic                                o_packet_valid,
    output logic [gbns_pkg::SEQ_PORT_W-1:0]     o_packet_seq,
    output logic [gbns_pkg::DATA_PORT_W-1:0]    o_packet_data,
    output logic [gbns_pkg::TMR_W-1:0]          o_timer_command,
    output logic [gbns_pkg::SEQ_PORT_W-1:0]     o_window_start,
    output logic [gbns_pkg::CNT_PORT_W-1:0]     o_outstanding,
    output logic                                o_last_of_run
);
    import gbns_pkg::*;

    localparam int USABLE = (WINDOW < SEQ_SPACE) ? WINDOW : (SEQ_SPACE - 1);
    localparam int SEQ_W  = $clog2(SEQ_SPACE);
    localparam int CNT_W  = $clog2(USABLE + 1);   // never wider than SEQ_W

    localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_SPACE - 1);
    localparam logic [SEQ_W-1:0] SEQ_MOD  = SEQ_W'(SEQ_SPACE);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(USABLE);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
        return (s == SEQ_LAST) ? '0 : s + SEQ_W'(1);
    endfunction

    // window state
    logic [SEQ_W-1:0] r_next_seq, n_next_seq;
    logic [SEQ_W-1:0] r_base_seq, n_base_seq;
    logic [CNT_W-1:0] r_in_flight, n_in_flight;

    // replay walk
    logic [SEQ_W-1:0] r_ptr;
    logic [CNT_W-1:0] r_idx;

    // packet store
    logic [PAYLOAD_BITS-1:0] mem [SEQ_SPACE];
    logic [PAYLOAD_BITS-1:0] r_rd_data;
    logic                    wr_en, rd_en;
    logic [SEQ_W-1:0]        rd_addr;

    // result register
    logic                    r_acc, r_pkt_valid, r_last;
    logic [SEQ_W-1:0]        r_pkt_seq;
    logic [PAYLOAD_BITS-1:0] r_pkt_data;
    logic [TMR_W-1:0]        r_timer;

    // step decode
    logic                    full, empty, ack_ok;
    logic [SEQ_W-1:0]        ack_s, ack_span, ptr_inc;
    logic                    replay_start;
    logic [PAYLOAD_BITS-1:0] send_data;

    assign empty     = (r_in_flight == '0);
    assign full      = (r_in_flight >= CNT_FULL);
    assign ack_s     = SEQ_W'(i_ack_seq);
    // modular distance from base
    assign ack_span  = (ack_s >= r_base_seq) ? ack_s - r_base_seq
                                             : ack_s - r_base_seq + SEQ_MOD;
    assign ack_ok    = i_ack_good && !empty && (32'(i_ack_seq) < SEQ_SPACE)
                       && (ack_span < SEQ_W'(r_in_flight));
    assign send_data = i_payload_word[PAYLOAD_BITS-1:0];
    assign ptr_inc   = seq_inc(r_ptr);

    assign replay_start           = i_cmd.accept && (i_operation == OP_TIMEOUT) && !empty;
    assign o_status.replay_needed = (i_operation == OP_TIMEOUT) && !empty;
    assign o_status.out_last      = r_last;

    assign wr_en   = i_cmd.accept && (i_operation == OP_SEND) && !full;
    assign rd_en   = replay_start || i_cmd.replay_next;
    assign rd_addr = replay_start ? r_base_seq : ptr_inc;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_next_seq] <= send_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        n_next_seq  = r_next_seq;
        n_base_seq  = r_base_seq;
        n_in_flight = r_in_flight;
        if (i_cmd.accept) begin
            case (i_operation)
                OP_SEND: begin
                    if (!full) begin
                        n_next_seq  = seq_inc(r_next_seq);
                        n_in_flight = r_in_flight + CNT_ONE;
                    end
                end
                OP_ACK: begin
                    if (ack_ok) begin
                        n_base_seq  = seq_inc(ack_s);
                        n_in_flight = r_in_flight - CNT_W'(ack_span) - CNT_ONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_seq  <= '0;
            r_base_seq  <= '0;
            r_in_flight <= '0;
        end else begin
            r_next_seq  <= n_next_seq;
            r_base_seq  <= n_base_seq;
            r_in_flight <= n_in_flight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_acc       <= 1'b0;
            r_pkt_valid <= 1'b0;
            r_pkt_seq   <= '0;
            r_pkt_data  <= '0;
            r_timer     <= TMR_NONE;
            r_last      <= 1'b1;
            r_ptr       <= r_base_seq;
            r_idx       <= '0;
            case (i_operation)
                OP_SEND: begin
                    if (!full) begin
                        r_acc       <= 1'b1;
                        r_pkt_valid <= 1'b1;
                        r_pkt_seq   <= r_next_seq;
                        r_pkt_data  <= send_data;
                        r_timer     <= empty ? TMR_START : TMR_NONE;
                    end
                end
                OP_ACK: begin
                    if (ack_ok) begin
                        r_timer <= (n_in_flight == '0) ? TMR_STOP : TMR_START;
                    end
                end
                OP_TIMEOUT: begin
                    // with packets in flight the result is loaded after the fetch
                    r_timer <= TMR_START;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.replay_load) begin
            r_acc       <= 1'b0;
            r_pkt_valid <= 1'b1;
            r_pkt_seq   <= r_ptr;
            r_pkt_data  <= r_rd_data;
            r_timer     <= (r_idx == '0) ? TMR_START : TMR_NONE;
            r_last      <= (CNT_W'(r_idx + CNT_ONE) == r_in_flight);
        end else if (i_cmd.replay_next) begin
            r_ptr <= ptr_inc;
            r_idx <= r_idx + CNT_ONE;
        end
    end

    assign o_accepted      = r_acc;
    assign o_packet_valid  = r_pkt_valid;
    assign o_packet_seq    = SEQ_PORT_W'(r_pkt_seq);
    assign o_packet_data   = DATA_PORT_W'(r_pkt_data);
    assign o_timer_command = r_timer;
    assign o_window_start  = SEQ_PORT_W'(r_base_seq);
    assign o_outstanding   = CNT_PORT_W'(r_in_flight);
    assign o_last_of_run   = r_last;

endmodule

>>> design/go_back_n_sender_core.sv
// Go-back-n ARQ sender: window bookkeeping, packet store and retransmission walk.
// Depends on gbns_pkg, gbns_ctrl and gbns_datapath.
//
// One item is taken at a time; the input stalls until every result of that item
// has been transferred. A send, an ack, an unused code or a timeout with nothing
// outstanding gives one result, ready the cycle after the input transfer. A
// timeout with N > 0 packets outstanding gives N results: each replayed entry is
// first read from the registered packet store and then presented as a result.
// The packet store needs no clearing after reset; only entries written by a send
// are read.
// The timer itself and checksum checking live outside the block.
module go_back_n_sender_core #(
    parameter int WINDOW       = gbns_pkg::DEF_WINDOW,
    parameter int SEQ_SPACE    = gbns_pkg::DEF_SEQ_SPACE,
    parameter int PAYLOAD_BITS = gbns_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [gbns_pkg::OP_W-1:0]        i_operation,
    input  logic [gbns_pkg::DATA_PORT_W-1:0] i_payload_word,
    input  logic [gbns_pkg::SEQ_PORT_W-1:0]  i_ack_seq,
    input  logic                             i_ack_good,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_accepted,
    output logic                             o_packet_valid,
    output logic [gbns_pkg::SEQ_PORT_W-1:0]  o_packet_seq,
    output logic [gbns_pkg::DATA_PORT_W-1:0] o_packet_data,
    output logic [gbns_pkg::TMR_W-1:0]       o_timer_command,
    output logic [gbns_pkg::SEQ_PORT_W-1:0]  o_window_start,
    output logic [gbns_pkg::CNT_PORT_W-1:0]  o_outstanding,
    output logic                             o_last_of_run
);
    import gbns_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    gbns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    gbns_datapath #(
        .WINDOW       (WINDOW),
        .SEQ_SPACE    (SEQ_SPACE),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_operation     (i_operation),
        .i_payload_word  (i_payload_word),
        .i_ack_seq       (i_ack_seq),
        .i_ack_good      (i_ack_good),
        .o_accepted      (o_accepted),
        .o_packet_valid  (o_packet_valid),
        .o_packet_seq    (o_packet_seq),
        .o_packet_data   (o_packet_data),
        .o_timer_command (o_timer_command),
        .o_window_start  (o_window_start),
        .o_outstanding   (o_outstanding),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

>>> verif/gbns_tb_pkg.sv
// Scoreboard for the go-back-n sender core bench: the result record and a
// window predictor that queues the expected results of each input transfer.
// Depends on gbns_pkg.
package gbns_tb_pkg;
    import gbns_pkg::*;

    localparam int SEQ_SZ = DEF_SEQ_SPACE;
    localparam int WIN_SZ = (DEF_WINDOW < DEF_SEQ_SPACE) ? DEF_WINDOW : DEF_SEQ_SPACE - 1;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic                   accepted;
        logic                   pkt_valid;
        logic [SEQ_PORT_W-1:0]  pkt_seq;
        logic [DATA_PORT_W-1:0] pkt_data;
        logic [TMR_W-1:0]       timer_cmd;
        logic [SEQ_PORT_W-1:0]  win_start;
        logic [CNT_PORT_W-1:0]  outst;
        logic                   last_one;
    } t_sender_result;

    class sender_scoreboard;
        t_sender_result         expected_q[$];
        logic [DATA_PORT_W-1:0] pkt_store[SEQ_SZ];
        int unsigned            next_seq;
        int unsigned            base_seq;
        int unsigned            in_flight;
        int unsigned            mismatches;
        int unsigned            results_seen;
        int unsigned            refused;
        int unsigned            replays;

        function new();
            next_seq     = 0;
            base_seq     = 0;
            in_flight    = 0;
            mismatches   = 0;
            results_seen = 0;
            refused      = 0;
            replays      = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // window fields always reflect the state after the step
        function void push_result(logic acc, logic vld, int unsigned seq,
                                  logic [DATA_PORT_W-1:0] data, logic [TMR_W-1:0] tmr,
                                  logic last_one);
            t_sender_result r;
            r.accepted  = acc;
            r.pkt_valid = vld;
            r.pkt_seq   = SEQ_PORT_W'(seq);
            r.pkt_data  = data;
            r.timer_cmd = tmr;
            r.win_start = SEQ_PORT_W'(base_seq);
            r.outst     = CNT_PORT_W'(in_flight);
            r.last_one  = last_one;
            expected_q.push_back(r);
        endfunction

        function void note_input(logic [OP_W-1:0] op, logic [DATA_PORT_W-1:0] payload,
                                 logic [SEQ_PORT_W-1:0] ack, logic good);
            int unsigned span;
            int unsigned seq;
            int unsigned i;
            case (op)
                OP_SEND: begin
                    if (in_flight >= WIN_SZ) begin
                        refused++;
                        push_result(1'b0, 1'b0, 0, '0, TMR_NONE, 1'b1);
                    end else begin
                        seq = next_seq;
                        pkt_store[seq] = payload;
                        next_seq = (seq + 1) % SEQ_SZ;
                        in_flight++;
                        push_result(1'b1, 1'b1, seq, payload,
                                    (in_flight == 1) ? TMR_START : TMR_NONE, 1'b1);
                    end
                end
                OP_ACK: begin
                    span = (int'(ack) + SEQ_SZ - base_seq) % SEQ_SZ;
                    if (!good || in_flight == 0 || int'(ack) >= SEQ_SZ
                        || span >= in_flight) begin
                        push_result(1'b0, 1'b0, 0, '0, TMR_NONE, 1'b1);
                    end else begin
                        // cumulative: everything up to and including ack is done
                        base_seq = (int'(ack) + 1) % SEQ_SZ;
                        in_flight = in_flight - span - 1;
                        push_result(1'b0, 1'b0, 0, '0,
                                    (in_flight == 0) ? TMR_STOP : TMR_START, 1'b1);
                    end
                end
                OP_TIMEOUT: begin
                    if (in_flight == 0) begin
                        push_result(1'b0, 1'b0, 0, '0, TMR_START, 1'b1);
                    end else begin
                        replays++;
                        for (i = 0; i < in_flight; i++) begin
                            seq = (base_seq + i) % SEQ_SZ;
                            push_result(1'b0, 1'b1, seq, pkt_store[seq],
                                        (i == 0) ? TMR_START : TMR_NONE, i + 1 == in_flight);
                        end
                    end
                end
                default: begin
                    push_result(1'b0, 1'b0, 0, '0, TMR_NONE, 1'b1);
                end
            endcase
        endfunction

        function string fmt(t_sender_result r);
            return $sformatf("acc=%0b pv=%0b seq=%0d data=%h tmr=%0d base=%0d out=%0d last=%0b",
                             r.accepted, r.pkt_valid, r.pkt_seq, r.pkt_data, r.timer_cmd,
                             r.win_start, r.outst, r.last_one);
        endfunction

        function void check_result(t_sender_result got);
            t_sender_result want;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d with nothing pending: %s", results_seen, fmt(got));
                return;
            end
            want = expected_q.pop_front();
            if (got.accepted !== want.accepted || got.pkt_valid !== want.pkt_valid ||
                got.pkt_seq !== want.pkt_seq || got.pkt_data !== want.pkt_data ||
                got.timer_cmd !== want.timer_cmd || got.win_start !== want.win_start ||
                got.outst !== want.outst || got.last_one !== want.last_one) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d mismatch", results_seen);
                    $display("  expected %s", fmt(want));
                    $display("  actual   %s", fmt(got));
                end
            end
        endfunction
    endclass

endpackage

>>> verif/tb.sv
// Top-level bench for go_back_n_sender_core: drives send/ack/timeout transfers
// with random gaps and output stalls, and checks every result in order.
// Depends on gbns_pkg, gbns_tb_pkg and the core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbns_pkg::*;
    import gbns_tb_pkg::*;

    localparam int RANDOM_ITEMS = 444;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 20;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic [OP_W-1:0]        i_operation    = OP_SEND;
    logic [DATA_PORT_W-1:0] i_payload_word = '0;
    logic [SEQ_PORT_W-1:0]  i_ack_seq      = '0;
    logic                   i_ack_good     = 1'b0;
    logic                   i_out_stall    = 1'b0;

    logic                   o_in_stall;
    logic                   o_out_valid;
    logic                   o_accepted;
    logic                   o_packet_valid;
    logic [SEQ_PORT_W-1:0]  o_packet_seq;
    logic [DATA_PORT_W-1:0] o_packet_data;
    logic [TMR_W-1:0]       o_timer_command;
    logic [SEQ_PORT_W-1:0]  o_window_start;
    logic [CNT_PORT_W-1:0]  o_outstanding;
    logic                   o_last_of_run;

    int unsigned      in_gap_pct    = 18;
    int unsigned      out_stall_pct = 52;
    int unsigned      cycles        = 0;
    int unsigned      items         = 0;
    sender_scoreboard sb;

    go_back_n_sender_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_payload_word  (i_payload_word),
        .i_ack_seq       (i_ack_seq),
        .i_ack_good      (i_ack_good),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_accepted      (o_accepted),
        .o_packet_valid  (o_packet_valid),
        .o_packet_seq    (o_packet_seq),
        .o_packet_data   (o_packet_data),
        .o_timer_command (o_timer_command),
        .o_window_start  (o_window_start),
        .o_outstanding   (o_outstanding),
        .o_last_of_run   (o_last_of_run)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver side: random stall, result check, watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result({o_accepted, o_packet_valid, o_packet_seq, o_packet_data,
                             o_timer_command, o_window_start, o_outstanding,
                             o_last_of_run});
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
            $display("tb: FAIL");
            $finish;
        end
    end

    // one input transfer; the predictor is updated at the accepting edge
    task automatic drive_item(input logic [OP_W-1:0] op, input logic [DATA_PORT_W-1:0] pay,
                              input logic [SEQ_PORT_W-1:0] ack, input logic good);
        while ($urandom_range(99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_payload_word <= pay;
        i_ack_seq      <= ack;
        i_ack_good     <= good;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_input(op, pay, ack, good);
        items++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int                     ph;
        int                     n;
        int unsigned            pick;
        logic [OP_W-1:0]        op;
        logic [DATA_PORT_W-1:0] pay;
        logic [SEQ_PORT_W-1:0]  ackv;
        logic                   good;

        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle corner cases, full window, partial acks, wrap of sequence
        drive_item(OP_UNUSED, '1, 3'd7, 1'b1);
        drive_item(OP_TIMEOUT, '0, 3'd0, 1'b0);
        drive_item(OP_ACK, '0, 3'd0, 1'b1);
        drive_item(OP_SEND, '0, 3'd0, 1'b0);
        drive_item(OP_SEND, '1, 3'd7, 1'b1);
        drive_item(OP_SEND, 64'hAAAA_AAAA_AAAA_AAAA, 3'd2, 1'b0);
        drive_item(OP_SEND, 64'h5555_5555_5555_5555, 3'd5, 1'b1);
        drive_item(OP_SEND, 64'h0123_4567_89AB_CDEF, 3'd0, 1'b1);  // window full
        drive_item(OP_TIMEOUT, '1, 3'd4, 1'b1);
        drive_item(OP_ACK, '0, 3'd1, 1'b0);   // bad checksum
        drive_item(OP_ACK, '0, 3'd6, 1'b1);   // beyond outstanding range
        drive_item(OP_ACK, '0, 3'd1, 1'b1);
        drive_item(OP_TIMEOUT, '0, 3'd0, 1'b0);
        drive_item(OP_ACK, '1, 3'd3, 1'b1);   // last one out, timer stop
        repeat (4)
            drive_item(OP_SEND, {$urandom, $urandom}, 3'($urandom_range(7)), 1'b1);
        drive_item(OP_ACK, '0, 3'd5, 1'b1);
        drive_item(OP_SEND, {$urandom, $urandom}, 3'd2, 1'b0);
        drive_item(OP_SEND, {$urandom, $urandom}, 3'd6, 1'b1);
        drive_item(OP_TIMEOUT, '0, 3'd3, 1'b1);  // replay crosses the wrap
        drive_item(OP_ACK, '0, 3'd1, 1'b1);
        drive_item(OP_UNUSED, {$urandom, $urandom}, 3'd5, 1'b0);
        drive_item(OP_ACK, '1, 3'd7, 1'b1);
        wait_drained();

        for (ph = 0; ph < 3; ph++) begin
            in_gap_pct    = (ph == 0) ? 18 : (ph == 1) ? 52 : 0;
            out_stall_pct = (ph == 0) ? 52 : (ph == 1) ? 18 : 0;
            for (n = 0; n < RANDOM_ITEMS / 3; n++) begin
                pick = $urandom_range(99);
                pay  = {$urandom, $urandom};
                if ($urandom_range(15) == 0)
                    pay = ($urandom_range(1) != 0) ? '1 : '0;
                ackv = 3'($urandom_range(7));
                good = ($urandom_range(9) != 0);
                if (pick < 48) begin
                    op = OP_SEND;
                end else if (pick < 80) begin
                    op = OP_ACK;
                    // mostly acks that land inside the outstanding range
                    if (sb.in_flight != 0 && $urandom_range(9) < 8)
                        ackv = 3'((sb.base_seq + $urandom_range(sb.in_flight - 1)) % SEQ_SZ);
                end else if (pick < 97) begin
                    op = OP_TIMEOUT;
                end else begin
                    op = OP_UNUSED;
                end
                drive_item(op, pay, ackv, good);
                if ($urandom_range(49) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run covered %0d input transfers and %0d results", items, sb.results_seen);
        $display("  %0d sends refused on a full window, %0d timeouts with replay",
                 sb.refused, sb.replays);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("%0d mismatches, %0d results never seen", sb.mismatches, sb.pending());
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
